### design/ssme_pkg.sv
`default_nettype none

package ssme_pkg;

  localparam int REF_DEPTH = 256;
  localparam int ADDR_W    = $clog2(REF_DEPTH);
  localparam int CNT_W     = $clog2(REF_DEPTH + 1);
  localparam int CAND_W    = $clog2(REF_DEPTH + 2);
  localparam int VAL_W     = 32;
  localparam int POS_W     = 9;
  localparam int OP_W      = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_PROBE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // flips two's complement order onto unsigned order
  localparam logic [VAL_W-1:0] SIGN_FLIP = 32'h8000_0000;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] key;
    logic [CNT_W-1:0] count;
  } srch_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } store_wr_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [CNT_W-1:0] pos;
  } srch_res_t;

  typedef struct packed {
    logic                    found;
    logic [POS_W-1:0]        position;
    logic                    set_done;
    logic                    is_subset;
    logic                    common_found;
    logic signed [VAL_W-1:0] common_value;
    logic                    ref_overflow;
  } result_t;

endpackage

`default_nettype wire

### design/ssme_cmd_if.sv
`default_nettype none

interface ssme_cmd_if;
  import ssme_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [VAL_W-1:0] value;
  logic                    last;

  modport source (output valid, operation, value, last, input ready);
  modport sink   (input valid, operation, value, last, output ready);
endinterface

`default_nettype wire

### design/ssme_res_if.sv
`default_nettype none

interface ssme_res_if;
  import ssme_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [POS_W-1:0]        position;
  logic                    set_done;
  logic                    is_subset;
  logic                    common_found;
  logic signed [VAL_W-1:0] common_value;
  logic                    ref_overflow;

  modport source (output valid, found, position, set_done, is_subset, common_found,
                  common_value, ref_overflow, input ready);
  modport sink   (input valid, found, position, set_done, is_subset, common_found,
                  common_value, ref_overflow, output ready);
endinterface

`default_nettype wire

### design/sorted_set_membership_engine.sv
`default_nettype none

// Sorted set membership engine.
// cmd channel (valid/ready) carries operation, value and last. Append adds value
// to the reference set if the store is not full and value is above the last
// stored entry; clear empties the reference set and the candidate flags; probe
// looks value up and gives one result on the res channel. Append and clear give
// no result. A probe takes one store read per binary search step, at most
// ceil(log2(ref_count + 1)) reads (9 for a full store of 256). cmd is taken
// only while no probe is in flight; the result is registered when it ends.
// res is a registered output. A new request is accepted while a result waits;
// if the next probe finishes before the receiver takes the waiting result, it
// parks in a holding register and cmd stays blocked until it moves out.
// Reset (rst, synchronous) empties the reference set and candidate flags and
// drops any pending result; store contents are not cleared, they are simply
// never read beyond the fill count.

module sorted_set_membership_engine (
  input  logic       clk,
  input  logic       rst,
  ssme_cmd_if.sink   cmd,
  ssme_res_if.source res
);
  import ssme_pkg::*;

  localparam logic [1:0] T_IDLE   = 2'd0;
  localparam logic [1:0] T_SEARCH = 2'd1;
  localparam logic [1:0] T_HOLD   = 2'd2;

  logic [1:0]        state;
  logic [CNT_W-1:0]  ref_count;
  logic              overflow_seen;
  logic [CAND_W-1:0] cand_count;
  logic              all_found;
  logic              have_common;
  logic [VAL_W-1:0]  first_common;
  logic [VAL_W-1:0]  last_val;
  logic [VAL_W-1:0]  probe_value;
  logic              probe_last;
  logic              out_valid;
  result_t           out_q, pend, res_now;

  srch_req_t         sreq;
  store_wr_t         swr;
  srch_res_t         sres;

  logic              accept, out_free, store_full, append_ok, load_out;
  logic [VAL_W-1:0]  in_b, last_b;
  logic [CAND_W-1:0] cand_next;
  logic              all_next, have_next, subset;
  logic [VAL_W-1:0]  first_next;

  assign cmd.ready = (state == T_IDLE) && !rst;
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || res.ready;
  assign load_out  = out_free && (((state == T_SEARCH) && sres.done) || (state == T_HOLD));

  always_comb begin
    in_b       = cmd.value ^ SIGN_FLIP;
    last_b     = last_val ^ SIGN_FLIP;
    store_full = (ref_count == CNT_W'(REF_DEPTH));
    append_ok  = !store_full && ((ref_count == '0) || (in_b > last_b));

    swr.en     = accept && (cmd.operation == OP_APPEND) && append_ok;
    swr.addr   = ref_count[ADDR_W-1:0];
    swr.data   = cmd.value;

    sreq.start = accept && (cmd.operation == OP_PROBE);
    sreq.key   = cmd.value;
    sreq.count = ref_count;

    cand_next  = (cand_count < CAND_W'(REF_DEPTH + 1)) ? cand_count + 1'b1 : cand_count;
    all_next   = all_found && sres.hit;
    have_next  = have_common || sres.hit;
    first_next = (sres.hit && !have_common) ? probe_value : first_common;
    subset     = probe_last && all_next && (cand_next <= CAND_W'(ref_count));

    res_now.found        = sres.hit;
    res_now.position     = POS_W'(sres.pos);
    res_now.set_done     = probe_last;
    res_now.is_subset    = subset;
    res_now.common_found = have_next;
    res_now.common_value = first_next;
    res_now.ref_overflow = overflow_seen;
  end

  ssme_search u_search (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .wr  (swr),
    .res (sres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      ref_count     <= '0;
      overflow_seen <= 1'b0;
      cand_count    <= '0;
      all_found     <= 1'b1;
      have_common   <= 1'b0;
      first_common  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            unique case (cmd.operation)
              OP_APPEND: begin
                if (store_full) begin
                  overflow_seen <= 1'b1;
                end else if (append_ok) begin
                  ref_count <= ref_count + 1'b1;
                  last_val  <= cmd.value;
                end
              end
              OP_PROBE: begin
                probe_value <= cmd.value;
                probe_last  <= cmd.last;
                state       <= T_SEARCH;
              end
              OP_CLEAR: begin
                ref_count     <= '0;
                overflow_seen <= 1'b0;
                cand_count    <= '0;
                all_found     <= 1'b1;
                have_common   <= 1'b0;
                first_common  <= '0;
              end
              default: ;
            endcase
          end
        end
        T_SEARCH: begin
          if (sres.done) begin
            // last probe closes the candidate set
            if (probe_last) begin
              cand_count   <= '0;
              all_found    <= 1'b1;
              have_common  <= 1'b0;
              first_common <= '0;
            end else begin
              cand_count   <= cand_next;
              all_found    <= all_next;
              have_common  <= have_next;
              first_common <= first_next;
            end
            if (out_free) begin
              out_q <= res_now;
              state <= T_IDLE;
            end else begin
              pend  <= res_now;
              state <= T_HOLD;
            end
          end
        end
        T_HOLD: begin
          if (out_free) begin
            out_q <= pend;
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign res.valid        = out_valid;
  assign res.found        = out_q.found;
  assign res.position     = out_q.position;
  assign res.set_done     = out_q.set_done;
  assign res.is_subset    = out_q.is_subset;
  assign res.common_found = out_q.common_found;
  assign res.common_value = out_q.common_value;
  assign res.ref_overflow = out_q.ref_overflow;

endmodule

`default_nettype wire

### design/ssme_search.sv
`default_nettype none

module ssme_search (
  input  logic                clk,
  input  logic                rst,
  input  ssme_pkg::srch_req_t req,
  input  ssme_pkg::store_wr_t wr,
  output ssme_pkg::srch_res_t res
);
  import ssme_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_MISS = 2'd2;

  logic [VAL_W-1:0]  mem [REF_DEPTH];
  logic [VAL_W-1:0]  rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;

  logic [1:0]        state;
  logic [VAL_W-1:0]  key_b;
  logic [CNT_W-1:0]  lo, hi, mid;
  logic [CNT_W-1:0]  lo_next, hi_next, mid_next;
  logic [CNT_W:0]    span_sum;
  logic [VAL_W-1:0]  elem_b;
  logic              eq, more;

  // window is [lo, hi); next read address is issued in the same cycle as the compare
  always_comb begin
    elem_b  = rd_data ^ SIGN_FLIP;
    eq      = (elem_b == key_b);
    more    = (elem_b > key_b);
    lo_next = lo;
    hi_next = hi;
    if (state == S_IDLE) begin
      lo_next = '0;
      hi_next = req.count;
    end else if (more) begin
      hi_next = mid;
    end else begin
      lo_next = mid + 1'b1;
    end
    span_sum = {1'b0, lo_next} + {1'b0, hi_next};
    mid_next = span_sum[CNT_W:1];
    rd_addr  = mid_next[ADDR_W-1:0];
    rd_en    = ((state == S_IDLE) && req.start && (req.count != '0)) ||
               ((state == S_LOOK) && !eq && (lo_next < hi_next));
    res.done = (state == S_MISS) ||
               ((state == S_LOOK) && (eq || (lo_next >= hi_next)));
    res.hit  = (state == S_LOOK) && eq;
    res.pos  = res.hit ? mid + 1'b1 : '0;
  end

  // appends only arrive while no lookup runs, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            key_b <= req.key ^ SIGN_FLIP;
            lo    <= lo_next;
            hi    <= hi_next;
            mid   <= mid_next;
            state <= (req.count != '0) ? S_LOOK : S_MISS;
          end
        end
        S_LOOK: begin
          if (res.done) begin
            state <= S_IDLE;
          end else begin
            lo  <= lo_next;
            hi  <= hi_next;
            mid <= mid_next;
          end
        end
        S_MISS:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/ssme_checker.sv
`default_nettype none

module ssme_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic                             found,
  input logic [ssme_pkg::POS_W-1:0]       position,
  input logic                             set_done,
  input logic                             is_subset,
  input logic                             common_found,
  input logic signed [ssme_pkg::VAL_W-1:0] common_value
);
  import ssme_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(position) && $stable(common_value))
    else $error("result changed while stalled");

  a_subset: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_subset |-> set_done && found)
    else $error("subset verdict without closing hit");

  a_position: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (found == (position != '0)))
    else $error("found and position disagree");

  a_common_hit: assert property (@(posedge clk) disable iff (rst)
    res_valid && found |-> common_found)
    else $error("hit not reflected in common flag");

  a_common_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !common_found |-> common_value == '0)
    else $error("common value set without common flag");

endmodule

bind sorted_set_membership_engine ssme_checker u_ssme_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .found        (res.found),
  .position     (res.position),
  .set_done     (res.set_done),
  .is_subset    (res.is_subset),
  .common_found (res.common_found),
  .common_value (res.common_value)
);

`default_nettype wire
